// ===== hw/rtl/sat_pkg.sv =====
package sat_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int KEY_W  = 20;
    localparam int ELEM_W = 21;
    localparam int LEN_W  = 21;
    localparam int VAL_W  = 32;
    localparam int BCNT_W = 7;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 2;

    // stream widths
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;

    // count saturates at the top of its field
    localparam logic [BCNT_W-1:0] BCNT_MAX = '1;
    localparam int BCNT_LIMIT = (ENTRIES < 127) ? ENTRIES : 127;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_COUNT  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ELEM_W-1:0]  elem_index;
        logic [VAL_W-1:0]   write_value;
        logic [VAL_W-1:0]   threshold;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [BCNT_W-1:0]  below_count;
        logic [VAL_W-1:0]   read_data;
    } res_t;

endpackage

// ===== hw/rtl/sat_ram.sv =====
module sat_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 52
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sat_engine.sv =====
module sat_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sat_pkg::req_t               in_req,
    input  logic [sat_pkg::LEN_W-1:0]   array_length,
    input  logic                        out_free,
    output logic                        res_valid,
    output sat_pkg::res_t               res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam int IDX_W = sat_pkg::IDX_W;
    localparam int CNT_W = sat_pkg::CNT_W;
    localparam int KEY_W = sat_pkg::KEY_W;
    localparam int VAL_W = sat_pkg::VAL_W;
    localparam int BCNT_W = sat_pkg::BCNT_W;

    state_t state_reg, state_next;

    // command held for the whole scan
    sat_pkg::cmd_t      cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               neg_reg;
    logic               range_err_reg;
    logic [VAL_W-1:0]   wval_reg;
    logic [VAL_W-1:0]   thr_reg;

    logic [sat_pkg::ENTRIES-1:0] valid_reg;

    logic [CNT_W-1:0]   addr_cnt_reg, addr_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]   rd_slot_reg;

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_slot_reg;
    logic [VAL_W-1:0]   hit_data_reg;
    logic               free_found_reg, free_next;
    logic [IDX_W-1:0]   free_slot_reg;
    logic [BCNT_W-1:0]  count_reg, count_next;

    logic                   accept;
    logic                   issue;
    logic                   scan_end;
    logic [KEY_W+VAL_W-1:0] ram_q;
    logic [KEY_W-1:0]       q_key;
    logic [VAL_W-1:0]       q_val;
    logic                   slot_valid;
    logic                   key_hit;
    logic                   free_hit;
    logic                   below;
    logic                   commit;
    logic                   rw_cmd;
    logic                   in_range_rw;
    logic                   alloc;
    logic                   upd;
    logic                   drop;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]       wr_val;
    logic                   range_err_in;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // index check against the logical length
    assign range_err_in = in_req.elem_index[KEY_W] ||
        ({1'b0, in_req.elem_index[KEY_W-1:0]} >= array_length);

    // scan address issue
    assign issue    = (state_reg == S_SCAN) && (addr_cnt_reg < CNT_W'(sat_pkg::ENTRIES));
    assign scan_end = (state_reg == S_SCAN) && (addr_cnt_reg == CNT_W'(sat_pkg::ENTRIES));

    sat_ram #(
        .DEPTH (sat_pkg::ENTRIES),
        .WIDTH (KEY_W + VAL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, wr_val}),
        .raddr (addr_cnt_reg[IDX_W-1:0]),
        .rdata (ram_q)
    );

    // examine the entry returned by the memory
    assign q_key      = ram_q[KEY_W+VAL_W-1:VAL_W];
    assign q_val      = ram_q[VAL_W-1:0];
    assign slot_valid = valid_reg[rd_slot_reg];
    assign key_hit    = rd_pend_reg && slot_valid && (q_key == key_reg) && !hit_reg;
    assign free_hit   = rd_pend_reg && !slot_valid && !free_found_reg;
    assign below      = rd_pend_reg && slot_valid && ($signed(q_val) < $signed(thr_reg));

    // state and scan counters
    always_comb begin
        state_next    = state_reg;
        addr_cnt_next = addr_cnt_reg;
        rd_pend_next  = issue;
        hit_next      = hit_reg || key_hit;
        free_next     = free_found_reg || free_hit;
        count_next    = count_reg;
        if (below && (count_reg != sat_pkg::BCNT_MAX)) begin
            count_next = count_reg + BCNT_W'(1);
        end
        if (issue) begin
            addr_cnt_next = addr_cnt_reg + CNT_W'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next    = S_SCAN;
                    addr_cnt_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    count_next    = '0;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // final decision for the command
    assign commit      = (state_reg == S_DONE) && out_free;
    assign rw_cmd      = (cmd_reg == sat_pkg::CMD_READ) || (cmd_reg == sat_pkg::CMD_WRITE);
    assign in_range_rw = rw_cmd && !range_err_reg;
    assign alloc       = in_range_rw && !hit_reg && free_found_reg;
    assign upd         = in_range_rw && hit_reg && (cmd_reg == sat_pkg::CMD_WRITE);
    assign drop        = (cmd_reg == sat_pkg::CMD_REMOVE) && !neg_reg && hit_reg;
    assign ram_we      = commit && (alloc || upd);
    assign ram_waddr   = hit_reg ? hit_slot_reg : free_slot_reg;
    assign wr_val      = (cmd_reg == sat_pkg::CMD_WRITE) ? wval_reg : '0;
    assign res_valid   = commit;

    always_comb begin
        res.status      = sat_pkg::STAT_OK;
        res.below_count = '0;
        res.read_data   = '0;
        if (rw_cmd && range_err_reg) begin
            res.status = sat_pkg::STAT_RANGE;
        end else if (in_range_rw && !hit_reg && !free_found_reg) begin
            res.status = sat_pkg::STAT_FULL;
        end
        if (in_range_rw && hit_reg && (cmd_reg == sat_pkg::CMD_READ)) begin
            res.read_data = hit_data_reg;
        end
        if (cmd_reg == sat_pkg::CMD_COUNT) begin
            res.below_count = count_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            addr_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            addr_cnt_reg   <= addr_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_next;
            count_reg      <= count_next;
            if (commit && alloc) begin
                valid_reg[free_slot_reg] <= 1'b1;
            end
            if (commit && drop) begin
                valid_reg[hit_slot_reg] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= in_req.cmd;
            key_reg       <= in_req.elem_index[KEY_W-1:0];
            neg_reg       <= in_req.elem_index[KEY_W];
            range_err_reg <= range_err_in;
            wval_reg      <= in_req.write_value;
            thr_reg       <= in_req.threshold;
        end
        rd_slot_reg <= addr_cnt_reg[IDX_W-1:0];
        if (key_hit) begin
            hit_slot_reg <= rd_slot_reg;
            hit_data_reg <= q_val;
        end
        if (free_hit) begin
            free_slot_reg <= rd_slot_reg;
        end
    end

    // read data only comes back during a scan
    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == S_SCAN))
        else $error("read return outside scan");

    // scan address never runs past the table
    a_addr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_cnt_reg <= CNT_W'(sat_pkg::ENTRIES))
        else $error("scan address overrun");

    // a new entry is marked valid after the commit
    a_alloc_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && alloc) |=> valid_reg[$past(free_slot_reg)])
        else $error("allocated slot not valid");

    // count cannot exceed the number of entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= BCNT_W'(sat_pkg::BCNT_LIMIT))
        else $error("count beyond table size");

    // memory is written only in the commit state
    a_write_at_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_DONE))
        else $error("memory write outside commit");

endmodule

// ===== hw/rtl/sparse_array_table.sv =====
// Sparse array table: a fixed set of (index, signed value) slots standing in
// for a sparse array of signed 32-bit values.
// Input stream s_*: s_tuser carries the command (read, write, remove, count
// below threshold), s_tdata the index, write value and threshold.
// Result stream m_*: one beat per command with read data, below count and
// status (ok, index out of range, table full).
// Configuration: cfg_valid/cfg_data write the logical array length; it is
// always ready. The user must write it only while no command is in flight;
// the block itself does not enforce this.
// Each command scans all table slots through the key/value memory, one slot
// per cycle at the single read port, and s_tready returns as the result is
// loaded into the output register.
// The output register holds a result while m_tready is low; a scan that
// finishes meanwhile waits for the register to free before committing.
// Reset (aresetn low, synchronous) empties the table and clears the length
// to zero; the memory contents need no clearing.
module sparse_array_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sat_pkg::LEN_W-1:0]     cfg_data,     // array_length
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sat_pkg::S_DATA_W-1:0]  s_tdata,      // elem_index, write_value, threshold
    input  logic [sat_pkg::CMD_W-1:0]     s_tuser,      // cmd
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sat_pkg::M_DATA_W-1:0]  m_tdata       // read_data, below_count, status
);

    localparam int RES_W = sat_pkg::VAL_W + sat_pkg::BCNT_W + sat_pkg::STAT_W;

    logic [sat_pkg::LEN_W-1:0]    len_reg;
    logic                         m_valid_reg;
    logic [sat_pkg::M_DATA_W-1:0] m_data_reg;
    sat_pkg::req_t                req;
    sat_pkg::res_t                res;
    logic                         res_valid;
    logic                         out_free;

    assign cfg_ready = 1'b1;

    // unpack the command beat
    assign req.cmd         = sat_pkg::cmd_t'(s_tuser);
    assign req.elem_index  = s_tdata[20:0];
    assign req.write_value = s_tdata[52:21];
    assign req.threshold   = s_tdata[84:53];

    assign out_free = !m_valid_reg || m_tready;

    sat_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (req),
        .array_length (len_reg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    // length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            len_reg <= cfg_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {{(sat_pkg::M_DATA_W - RES_W){1'b0}},
                           res.status, res.below_count, res.read_data};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
